FILE: src/fmpl_pkg.sv
// Package: shared types, codes and constants of the FLI multicolor pixel lookup
`default_nettype none

package fmpl_pkg;

  // Image memory geometry
  localparam int MEM_AW    = 16;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  // Default location of the per-line multicolor table
  localparam int LINE_TABLE_BASE_DEF = 4096;

  // Bitmap banks and layout
  localparam logic [15:0] BITMAP_BANK_A  = 16'h4000;
  localparam logic [15:0] BITMAP_BANK_B  = 16'h6000;
  localparam int          ROW_STRIDE     = 312;
  localparam logic [15:0] COLOR_OFFSET   = 16'h0400;
  localparam int          LINE_STRIDE    = 17;
  localparam int          MC_SPACING     = 5;
  localparam int          ATTR_ROW_BYTES = 40;

  // Line and column limits of the lower area
  localparam logic [7:0] LINE_LOWER     = 8'd192;
  localparam logic [7:0] LINE_BANK_B_END = 8'd200;
  localparam logic [7:0] LINE_SPLIT_END = 8'd208;
  localparam logic [7:0] COL_SPLIT      = 8'd96;

  // Operation codes
  localparam logic [1:0] OP_WRITE_BYTE = 2'd0;
  localparam logic [1:0] OP_READ_PIXEL = 2'd1;
  localparam logic [1:0] OP_SET_MC     = 2'd2;
  localparam logic [1:0] OP_NONE       = 2'd3;

  // Line-pair groups per area, one attribute base register each
  localparam int NUM_GROUPS = 4;

  // Input transaction
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  new_multicolor_one;
    logic [7:0]  new_multicolor_two;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [1:0] pixel_class;
    logic [7:0] pixel_color;
    logic [7:0] background_color;
    logic [7:0] foreground_color;
    logic [7:0] multicolor_one;
    logic [7:0] multicolor_two;
  } out_item_t;

  // Attribute base registers of one area
  typedef logic [NUM_GROUPS-1:0][15:0] attr_bank_t;

  // Which image address the address unit produces
  typedef enum logic [2:0] {
    ASEL_BMP,
    ASEL_CC,
    ASEL_CL,
    ASEL_MC1,
    ASEL_MC2,
    ASEL_WADDR
  } asel_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BMP,
    ST_CC,
    ST_CL,
    ST_MC1,
    ST_MC2,
    ST_WR1,
    ST_WR2,
    ST_FIN
  } state_t;

  // Bytes gathered for one pixel, handed to the color resolver
  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] x_lo;
    logic [7:0] bmp;
    logic [7:0] cc;
    logic [7:0] cl;
    logic [7:0] mc1;
    logic [7:0] mc2;
  } capture_t;

endpackage

`default_nettype wire

FILE: src/fmpl_addr.sv
// Address unit: image addresses of bitmap, attribute and multicolor bytes
`default_nettype none

module fmpl_addr import fmpl_pkg::*; #(
  parameter int LINE_TABLE_BASE = LINE_TABLE_BASE_DEF
) (
  input  wire in_item_t   item,
  input  wire asel_t      asel,
  input  wire attr_bank_t upper_attr_base,
  input  wire attr_bank_t lower_attr_base,
  output logic [15:0]     addr
);

  localparam logic [15:0] LTB         = 16'(LINE_TABLE_BASE);
  localparam logic [15:0] MC_ADJ_EVEN = 16'd2;
  localparam logic [15:0] MC_ADJ_ODD  = 16'hFFFD;
  localparam logic [15:0] MC_ADJ_HIGH = 16'hFFFF;
  localparam logic [15:0] MC_ADJ_SEAM = 16'hFFFC;

  logic [7:0]  x;
  logic [7:0]  y;
  logic [4:0]  row;
  logic [1:0]  grp;
  logic        bank_b;
  logic [15:0] bmp_addr;
  logic [15:0] attr_off;
  logic [15:0] attr_base;
  logic [15:0] cl_addr;
  logic [15:0] cc_addr;
  logic [15:0] line_pos;
  logic [15:0] mc_adj;
  logic [15:0] mc1_addr;
  logic [15:0] mc2_addr;

  assign x   = item.pixel_x;
  assign y   = item.pixel_y;
  assign row = y[7:3];
  assign grp = y[2:1];

  // Second bitmap bank covers the first lines of the lower area and the left columns of the lines after them
  assign bank_b = (y >= LINE_LOWER) &&
                  ((y < LINE_BANK_B_END) || ((y < LINE_SPLIT_END) && (x < COL_SPLIT)));

  // Bitmap byte: bank + row stride + cell column + raster line
  assign bmp_addr = (bank_b ? BITMAP_BANK_B : BITMAP_BANK_A) + 16'(ROW_STRIDE * row)
                  + {7'd0, x[7:2], 3'd0} + {8'd0, y};

  // Attribute bytes: base picked by area and line-pair group
  assign attr_off = 16'(ATTR_ROW_BYTES * row) + {10'd0, x[7:2]};

  always_comb begin
    if (y < LINE_LOWER) begin
      attr_base = upper_attr_base[grp];
    end else if (bank_b) begin
      attr_base = lower_attr_base[grp];
    end else begin
      attr_base = lower_attr_base[grp] - COLOR_OFFSET;
    end
  end

  assign cl_addr = attr_base + attr_off;
  assign cc_addr = cl_addr + COLOR_OFFSET;

  // Multicolor table entry of the line, with the per-parity correction
  assign line_pos = LTB + 16'(LINE_STRIDE * y);

  always_comb begin
    if (!y[0]) begin
      mc_adj = (y < LINE_LOWER) ? 16'd0 : MC_ADJ_EVEN;
    end else begin
      mc_adj = (y <= LINE_LOWER) ? MC_ADJ_ODD : MC_ADJ_HIGH;
    end
  end

  always_comb begin
    if (y == LINE_LOWER) begin
      mc1_addr = LTB + MC_ADJ_SEAM;
      mc2_addr = LTB + MC_ADJ_SEAM + 16'd2;
    end else begin
      mc1_addr = line_pos + mc_adj;
      mc2_addr = line_pos + mc_adj + 16'(MC_SPACING);
    end
  end

  // Pick the address for the current access
  always_comb begin
    case (asel)
      ASEL_BMP:   addr = bmp_addr;
      ASEL_CC:    addr = cc_addr;
      ASEL_CL:    addr = cl_addr;
      ASEL_MC1:   addr = mc1_addr;
      ASEL_MC2:   addr = mc2_addr;
      ASEL_WADDR: addr = item.mem_address;
      default:    addr = item.mem_address;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/fmpl_color.sv
// Color resolver: pixel class, attribute colors and the selected color
`default_nettype none

module fmpl_color import fmpl_pkg::*; (
  input  wire capture_t capt,
  output out_item_t     result
);

  logic [1:0] cls;
  logic [7:0] bg;
  logic [7:0] fg;
  logic [7:0] col;

  // Take the 2-bit class from the bitmap byte, leftmost pixel in the top bits
  always_comb begin
    case (capt.x_lo)
      2'd0:    cls = capt.bmp[7:6];
      2'd1:    cls = capt.bmp[5:4];
      2'd2:    cls = capt.bmp[3:2];
      2'd3:    cls = capt.bmp[1:0];
      default: cls = capt.bmp[1:0];
    endcase
  end

  // Combine nibbles of the two attribute bytes
  assign bg = {capt.cl[3:0], capt.cc[7:4]};
  assign fg = {capt.cl[7:4], capt.cc[3:0]};

  always_comb begin
    case (cls)
      2'd0:    col = capt.mc1;
      2'd1:    col = bg;
      2'd2:    col = fg;
      2'd3:    col = capt.mc2;
      default: col = capt.mc2;
    endcase
  end

  // Only a pixel read carries data; other operations answer with zeros
  always_comb begin
    if (capt.operation == OP_READ_PIXEL) begin
      result.pixel_class      = cls;
      result.pixel_color      = col;
      result.background_color = bg;
      result.foreground_color = fg;
      result.multicolor_one   = capt.mc1;
      result.multicolor_two   = capt.mc2;
    end else begin
      result = '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/fmpl_ctrl.sv
// Sequencer: image memory, access sequence, byte capture and output register
`default_nettype none

module fmpl_ctrl import fmpl_pkg::*; (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire             out_stall,
  output out_item_t       out_item,
  output in_item_t        item,
  output asel_t           asel,
  input  wire [15:0]      addr,
  output capture_t        capt,
  input  wire out_item_t  result
);

  logic [7:0] image_mem [MEM_DEPTH];
  logic [7:0] rdata;

  state_t     state;
  state_t     state_next;
  logic       accept;
  logic       load;
  logic       mem_en;
  logic       mem_we;
  logic [7:0] wdata;
  logic [7:0] bmp;
  logic [7:0] cc;
  logic [7:0] cl;
  logic [7:0] mc1;

  // First state of a transaction, by its operation
  function automatic state_t start_state(input logic [1:0] op);
    state_t s;
    case (op)
      OP_READ_PIXEL: s = ST_BMP;
      OP_WRITE_BYTE: s = ST_WR1;
      OP_SET_MC:     s = ST_WR1;
      OP_NONE:       s = ST_FIN;
      default:       s = ST_FIN;
    endcase
    return s;
  endfunction

  assign accept = in_valid && !in_stall;

  // Next state and access control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    asel       = ASEL_BMP;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    wdata      = 8'h00;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = start_state(in_item.operation);
        end
      end
      ST_BMP: begin
        asel       = ASEL_BMP;
        mem_en     = 1'b1;
        state_next = ST_CC;
      end
      ST_CC: begin
        asel       = ASEL_CC;
        mem_en     = 1'b1;
        state_next = ST_CL;
      end
      ST_CL: begin
        asel       = ASEL_CL;
        mem_en     = 1'b1;
        state_next = ST_MC1;
      end
      ST_MC1: begin
        asel       = ASEL_MC1;
        mem_en     = 1'b1;
        state_next = ST_MC2;
      end
      ST_MC2: begin
        asel       = ASEL_MC2;
        mem_en     = 1'b1;
        state_next = ST_FIN;
      end
      ST_WR1: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        if (item.operation == OP_WRITE_BYTE) begin
          asel       = ASEL_WADDR;
          wdata      = item.mem_data;
          state_next = ST_FIN;
        end else begin
          asel       = ASEL_MC1;
          wdata      = item.new_multicolor_one;
          state_next = ST_WR2;
        end
      end
      ST_WR2: begin
        asel       = ASEL_MC2;
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        wdata      = item.new_multicolor_two;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // Hand over the result once the output register frees up
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          in_stall   = 1'b0;
          state_next = in_valid ? start_state(in_item.operation) : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

  // Single-port image memory with a registered read
  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        image_mem[addr] <= wdata;
      end else begin
        rdata <= image_mem[addr];
      end
    end
  end

  // Capture each byte from the read register while the next state runs
  always_ff @(posedge clk) begin
    if (state == ST_CC) begin
      bmp <= rdata;
    end
    if (state == ST_CL) begin
      cc <= rdata;
    end
    if (state == ST_MC1) begin
      cl <= rdata;
    end
    if (state == ST_MC2) begin
      mc1 <= rdata;
    end
  end

  // Last multicolor byte stays in the read register until the result loads
  always_comb begin
    capt.operation = item.operation;
    capt.x_lo      = item.pixel_x[1:0];
    capt.bmp       = bmp;
    capt.cc        = cc;
    capt.cl        = cl;
    capt.mc1       = mc1;
    capt.mc2       = rdata;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= result;
    end
  end

`ifndef ASSERT_OFF
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_FIN) |-> in_stall)
    else $error("input taken while an access sequence is running");

  a_mem_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FIN) |-> !mem_en)
    else $error("image memory accessed outside the access sequence");

  a_read_start: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.operation == OP_READ_PIXEL) |=> (state == ST_BMP))
    else $error("pixel read did not start with the bitmap fetch");

  a_read_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MC2) |=> (state == ST_FIN && !mem_en))
    else $error("second multicolor byte not held for the result");
`endif

endmodule

`default_nettype wire

FILE: src/fli_multicolor_pixel_lookup.sv
// Top level: attribute base registers, APB port and the lookup datapath
//
//  channel | handshake                         | payload
//  --------+-----------------------------------+-----------------------
//  in      | in_valid / in_stall               | in_item  (in_item_t)
//  out     | out_valid / out_stall             | out_item (out_item_t)
//  cfg     | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// A pixel read issues five byte reads of the single-port image memory
// (bitmap, two attributes, two multicolors), then loads the result.
// A byte write does one memory write, a multicolor set two, an unused code none.
// The next transaction is taken in the cycle the result loads.
// Reset clears the state, out_valid and the base registers; the image memory is not cleared.
// A held result stalls the input only while the next result is ready.
`default_nettype none

module fli_multicolor_pixel_lookup import fmpl_pkg::*; #(
  parameter int LINE_TABLE_BASE = LINE_TABLE_BASE_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire             out_stall,
  output out_item_t       out_item,
  input  wire             psel,
  input  wire             penable,
  input  wire             pwrite,
  input  wire [4:0]       paddr,
  input  wire [31:0]      pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  attr_bank_t  upper_attr_base;
  attr_bank_t  lower_attr_base;
  in_item_t    item;
  asel_t       asel;
  logic [15:0] addr;
  capture_t    capt;
  out_item_t   result;
  logic        cfg_write;
  logic [1:0]  cfg_grp;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_grp   = paddr[3:2];

  // Register writes: upper area first, lower area at the second half
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_attr_base <= '0;
      lower_attr_base <= '0;
    end else if (cfg_write) begin
      if (!paddr[4]) begin
        upper_attr_base[cfg_grp] <= pwdata[15:0];
      end else begin
        lower_attr_base[cfg_grp] <= pwdata[15:0];
      end
    end
  end

  // Register read back
  always_comb begin
    if (!paddr[4]) begin
      prdata = {16'd0, upper_attr_base[cfg_grp]};
    end else begin
      prdata = {16'd0, lower_attr_base[cfg_grp]};
    end
  end

  fmpl_addr #(
    .LINE_TABLE_BASE(LINE_TABLE_BASE)
  ) u_addr (
    .item            (item),
    .asel            (asel),
    .upper_attr_base (upper_attr_base),
    .lower_attr_base (lower_attr_base),
    .addr            (addr)
  );

  fmpl_color u_color (
    .capt   (capt),
    .result (result)
  );

  fmpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .item      (item),
    .asel      (asel),
    .addr      (addr),
    .capt      (capt),
    .result    (result)
  );

endmodule

`default_nettype wire

FILE: tb/fli_multicolor_pixel_lookup_tb.sv
// Self-checking testbench of the FLI multicolor pixel lookup: directed table, then random phases
`timescale 1ns / 1ps

module fli_multicolor_pixel_lookup_tb;
  import fmpl_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int REPORT_LIMIT    = 10;
  localparam int NUM_REGS        = 2 * NUM_GROUPS;

  // Register map: upper area bases first, then lower area bases
  localparam int REG_UPPER0 = 0;
  localparam int REG_LOWER0 = NUM_GROUPS;

  // Slots of the five image bytes that one pixel read touches
  localparam int SLOT_BMP = 0;
  localparam int SLOT_CC  = 1;
  localparam int SLOT_CL  = 2;
  localparam int SLOT_MC1 = 3;
  localparam int SLOT_MC2 = 4;
  localparam int NUM_SLOTS = 5;

  // Idle and stall odds per phase mode, in percent
  localparam int IDLE_PCT  [4] = '{0, 78, 0, 7};
  localparam int STALL_PCT [4] = '{0, 0, 78, 7};

  typedef logic [NUM_SLOTS-1:0][15:0] addr_set_t;

  typedef struct packed {
    in_item_t  item;
    logic      chk;
    out_item_t exp;
  } row_t;

  // Directed rows; chk set means the typed result is the expectation
  localparam row_t DIR_ROWS [21] = '{
    '{'{OP_NONE,       16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '0},
    '{'{OP_WRITE_BYTE, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '0},
    '{'{OP_WRITE_BYTE, 16'h0000, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '0},
    '{'{OP_SET_MC,     16'h0000, 8'h00, 8'h00, 8'd0,   8'hFF, 8'h00}, 1'b1, '0},
    '{'{OP_SET_MC,     16'hFFFF, 8'hFF, 8'hFF, 8'd191, 8'h00, 8'hFF}, 1'b1, '0},
    '{'{OP_SET_MC,     16'h1234, 8'h5A, 8'h10, 8'd192, 8'hA5, 8'h5A}, 1'b1, '0},
    '{'{OP_SET_MC,     16'h4321, 8'hA5, 8'h20, 8'd193, 8'h3C, 8'hC3}, 1'b1, '0},
    '{'{OP_SET_MC,     16'h0000, 8'h00, 8'h00, 8'd255, 8'hFF, 8'hFF}, 1'b1, '0},
    '{'{OP_SET_MC,     16'hAAAA, 8'h55, 8'h00, 8'd254, 8'h81, 8'h18}, 1'b1, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd0,   8'd0,   8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'hFFFF, 8'hFF, 8'd159, 8'd191, 8'hFF, 8'hFF}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd0,   8'd192, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd95,  8'd200, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd96,  8'd200, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd3,   8'd207, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd0,   8'd208, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'hFFFF, 8'hFF, 8'd255, 8'd255, 8'hFF, 8'hFF}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd160, 8'd1,   8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd2,   8'd193, 8'h00, 8'h00}, 1'b0, '0},
    '{'{OP_NONE,       16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '0},
    '{'{OP_READ_PIXEL, 16'h0000, 8'h00, 8'd1,   8'd254, 8'h00, 8'h00}, 1'b0, '0}
  };

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: image copy, written-byte map and attribute bases
  logic [7:0]  image_copy [65536];
  bit          written    [65536];
  attr_bank_t  upper_cfg = '0;
  attr_bank_t  lower_cfg = '0;

  out_item_t   pending_results [$];
  out_item_t   oldest;
  int          errors      = 0;
  int          sent        = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          quiet_cycles = 0;
  bit          hold_req    = 1'b0;

  fli_multicolor_pixel_lookup i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Address of multicolor byte z of line y in the line table
  function automatic logic [15:0] mc_loc(logic [7:0] y, int z);
    int p;
    p = LINE_TABLE_BASE_DEF + int'(y) * LINE_STRIDE + MC_SPACING * z;
    if (!y[0]) begin
      if (y < LINE_LOWER) return 16'(p);
      if (y == LINE_LOWER) return 16'(LINE_TABLE_BASE_DEF - 4 + 2 * z);
      return 16'(p + 2);
    end
    if (y <= LINE_LOWER) return 16'(p - 3);
    return 16'(p - 1);
  endfunction

  function automatic bit in_second_bank(logic [7:0] x, logic [7:0] y);
    return y >= LINE_LOWER &&
           (y < LINE_BANK_B_END || (y < LINE_SPLIT_END && x < COL_SPLIT));
  endfunction

  // Image addresses of the bytes that build pixel (x, y)
  function automatic addr_set_t pixel_addrs(logic [7:0] x, logic [7:0] y);
    addr_set_t   a;
    int          g;
    int          ap;
    logic [15:0] base;
    logic [15:0] bank;
    bank = in_second_bank(x, y) ? BITMAP_BANK_B : BITMAP_BANK_A;
    g    = int'(y[2:1]);
    ap   = int'(y[7:3]) * ATTR_ROW_BYTES + int'(x[7:2]);
    if (y < LINE_LOWER) base = upper_cfg[g];
    else if (in_second_bank(x, y)) base = lower_cfg[g];
    else base = lower_cfg[g] - COLOR_OFFSET;
    a[SLOT_BMP] = 16'(int'(bank) + ROW_STRIDE * int'(y[7:3]) +
                      2 * int'({x[7:2], 2'b00}) + int'(y));
    a[SLOT_CC]  = 16'(int'(base) + ap + int'(COLOR_OFFSET));
    a[SLOT_CL]  = 16'(int'(base) + ap);
    a[SLOT_MC1] = mc_loc(y, 0);
    a[SLOT_MC2] = mc_loc(y, 1);
    return a;
  endfunction

  // Apply one transaction to the image copy and compute its result
  function automatic out_item_t predict_lookup(in_item_t it);
    out_item_t  r;
    addr_set_t  a;
    logic [7:0] bmp;
    logic [7:0] cc;
    logic [7:0] cl;
    int         sh;
    r = '0;
    case (it.operation)
      OP_WRITE_BYTE: image_copy[it.mem_address] = it.mem_data;
      OP_SET_MC: begin
        image_copy[mc_loc(it.pixel_y, 0)] = it.new_multicolor_one;
        image_copy[mc_loc(it.pixel_y, 1)] = it.new_multicolor_two;
      end
      OP_READ_PIXEL: begin
        a   = pixel_addrs(it.pixel_x, it.pixel_y);
        bmp = image_copy[a[SLOT_BMP]];
        cc  = image_copy[a[SLOT_CC]];
        cl  = image_copy[a[SLOT_CL]];
        sh  = 6 - 2 * int'(it.pixel_x[1:0]);
        r.pixel_class      = bmp[sh +: 2];
        r.background_color = {cl[3:0], cc[7:4]};
        r.foreground_color = {cl[7:4], cc[3:0]};
        r.multicolor_one   = image_copy[a[SLOT_MC1]];
        r.multicolor_two   = image_copy[a[SLOT_MC2]];
        case (r.pixel_class)
          2'd0: r.pixel_color = r.multicolor_one;
          2'd1: r.pixel_color = r.background_color;
          2'd2: r.pixel_color = r.foreground_color;
          default: r.pixel_color = r.multicolor_two;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [15:0] phase_base(int ph, int idx);
    case (ph)
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return idx[0] ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one transaction, then record its expected result once taken
  task automatic send_item(in_item_t it, bit chk, out_item_t typed);
    out_item_t predicted;
    if (it.operation == OP_WRITE_BYTE) begin
      written[it.mem_address] = 1'b1;
    end else if (it.operation == OP_SET_MC) begin
      written[mc_loc(it.pixel_y, 0)] = 1'b1;
      written[mc_loc(it.pixel_y, 1)] = 1'b1;
    end
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_lookup(it);
    pending_results.push_back(chk ? typed : predicted);
    sent++;
  endtask

  // Write every never-written byte that pixel (x, y) reads
  task automatic fill_pixel_bytes(logic [7:0] x, logic [7:0] y);
    addr_set_t a;
    in_item_t  it;
    a = pixel_addrs(x, y);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!written[a[s]]) begin
        it = random_item();
        it.operation   = OP_WRITE_BYTE;
        it.mem_address = a[s];
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  // Mostly on-screen columns; lines bunched around the lower area limits
  task automatic pick_pixel(output logic [7:0] x, output logic [7:0] y);
    x = ($urandom_range(99) < 85) ? 8'($urandom_range(159)) : 8'($urandom_range(255));
    y = ($urandom_range(99) < 30) ? 8'($urandom_range(212, 188)) : 8'($urandom_range(255));
  endtask

  task automatic random_step();
    in_item_t   it;
    addr_set_t  a;
    logic [7:0] x;
    logic [7:0] y;
    int         r;
    r  = $urandom_range(99);
    it = random_item();
    pick_pixel(x, y);
    if (r < 55) begin
      // Well-formed read: maybe set the line colors, fill the bytes, look up
      if ($urandom_range(3) == 0) begin
        it.operation = OP_SET_MC;
        it.pixel_y   = y;
        send_item(it, 1'b0, '0);
        it = random_item();
      end
      fill_pixel_bytes(x, y);
      it.operation = OP_READ_PIXEL;
      it.pixel_x   = x;
      it.pixel_y   = y;
    end else if (r < 65) begin
      // Overwrite a byte that some pixel reads
      a = pixel_addrs(x, y);
      it.operation   = OP_WRITE_BYTE;
      it.mem_address = a[$urandom_range(NUM_SLOTS - 1)];
    end else if (r < 75) begin
      it.operation = OP_WRITE_BYTE;
    end else if (r < 90) begin
      it.operation = OP_SET_MC;
    end else begin
      it.operation = OP_NONE;
    end
    send_item(it, 1'b0, '0);
  endtask

  // Write one base register, then read it back in a second access
  task automatic write_attr_base(int idx, logic [15:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx < REG_LOWER0) upper_cfg[idx - REG_UPPER0] = val;
    else lower_cfg[idx - REG_LOWER0] = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(val)) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("register %0d read back %h, expected %h", idx, prdata, 32'(val));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop valid and let every outstanding result come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("result with no expectation: %h", out_item);
      end else begin
        oldest = pending_results.pop_front();
        if (out_item.pixel_class      !== oldest.pixel_class      ||
            out_item.pixel_color      !== oldest.pixel_color      ||
            out_item.background_color !== oldest.background_color ||
            out_item.foreground_color !== oldest.foreground_color ||
            out_item.multicolor_one   !== oldest.multicolor_one   ||
            out_item.multicolor_two   !== oldest.multicolor_two) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display({"result mismatch (exp/got): class %0d/%0d color %h/%h ",
                      "bg %h/%h fg %h/%h mc1 %h/%h mc2 %h/%h"},
                     oldest.pixel_class, out_item.pixel_class,
                     oldest.pixel_color, out_item.pixel_color,
                     oldest.background_color, out_item.background_color,
                     oldest.foreground_color, out_item.foreground_color,
                     oldest.multicolor_one, out_item.multicolor_one,
                     oldest.multicolor_two, out_item.multicolor_two);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    row_t row;
    bit   hold_done;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table on the reset register values
    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      if (row.item.operation == OP_READ_PIXEL)
        fill_pixel_bytes(row.item.pixel_x, row.item.pixel_y);
      send_item(row.item, row.chk, row.exp);
    end

    // Random phases, each with its own bases and idle and stall mode
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      for (int r = 0; r < NUM_REGS; r++) write_attr_base(r, phase_base(ph, r));
      idle_pct  = IDLE_PCT[ph % 4];
      stall_pct = STALL_PCT[ph % 4];
      sent      = 0;
      hold_done = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if (ph == 0 && !hold_done && sent >= ITEMS_PER_PHASE / 2) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        random_step();
      end
    end

    settle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/fmpl_pkg.sv
src/fmpl_addr.sv
src/fmpl_color.sv
src/fmpl_ctrl.sv
src/fli_multicolor_pixel_lookup.sv
tb/fli_multicolor_pixel_lookup_tb.sv
